### rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared types, register map and reset values of the collision safety
// mode selector
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int DIST_W   = 16;
    localparam int TTC_W    = 16;
    localparam int SPEED_W  = 14;
    localparam int TICK_W   = 10;
    localparam int FRAME_W  = 8;
    localparam int TIMER_W  = 16;
    localparam int Q8_W     = 10;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REGIDX_W = 3;

    localparam int unsigned HOLD_TIME_MS_DEF     = 2000;
    localparam int unsigned RECOVERY_TIME_MS_DEF = 1000;
    localparam int unsigned FOLLOW_ENTER_Q8_DEF  = 384;
    localparam int unsigned FOLLOW_EXIT_Q8_DEF   = 448;

    localparam logic [DIST_W-1:0]  IMM_BRAKE_DIST_RST = 16'd500;
    localparam logic [DIST_W-1:0]  BRAKE_DIST_RST     = 16'd1000;
    localparam logic [TTC_W-1:0]   BRAKE_TTC_RST      = 16'd1500;
    localparam logic [TTC_W-1:0]   WARN_TTC_RST       = 16'd3000;
    localparam logic [TTC_W-1:0]   WARN_EXIT_TTC_RST  = 16'd3500;
    localparam logic [FRAME_W-1:0] CONFIRM_FRAMES_RST = 8'd3;
    localparam logic [DIST_W-1:0]  RESUME_DIST_RST    = 16'd800;
    localparam logic [SPEED_W-1:0] STOP_SPEED_RST     = 14'd30;

    localparam logic [REGIDX_W-1:0] REG_IMM_BRAKE_DIST = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BRAKE_DIST     = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_BRAKE_TTC      = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_WARN_TTC       = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_WARN_EXIT_TTC  = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_CONFIRM_FRAMES = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_RESUME_DIST    = 3'd6;
    localparam logic [REGIDX_W-1:0] REG_STOP_SPEED     = 3'd7;

    typedef enum logic [2:0] {
        MODE_CRUISE,
        MODE_FOLLOW,
        MODE_WARN,
        MODE_BRAKE,
        MODE_FAULT
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE,
        EVT_FAULT_ENTERED,
        EVT_RECOVERED
    } event_t;

    typedef struct packed {
        logic [DIST_W-1:0]  imm_brake_dist;
        logic [DIST_W-1:0]  brake_dist;
        logic [TTC_W-1:0]   brake_ttc;
        logic [TTC_W-1:0]   warn_ttc;
        logic [TTC_W-1:0]   warn_exit_ttc;
        logic [FRAME_W-1:0] confirm_frames;
        logic [DIST_W-1:0]  resume_dist;
        logic [SPEED_W-1:0] stop_speed;
    } cfg_t;

    typedef struct packed {
        logic               sensors_healthy;
        logic               target_valid;
        logic               target_stale;
        logic [DIST_W-1:0]  target_distance;
        logic [DIST_W-1:0]  desired_gap;
        logic [TTC_W-1:0]   time_to_collision;
        logic [SPEED_W-1:0] ego_speed;
        logic [TICK_W-1:0]  tick_ms;
    } item_t;

    typedef struct packed {
        mode_t  mode;
        event_t evt;
        logic   hold;
    } res_t;

endpackage

### rtl/csm_cfg_regs.sv
// ----------------------------------------------------------------------------
// csm_cfg_regs
// threshold registers behind the apb port, with read back
// ----------------------------------------------------------------------------
module csm_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csm_pkg::ADDR_W-1:0]  paddr,
    input  logic [csm_pkg::DATA_W-1:0]  pwdata,
    output logic [csm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output csm_pkg::cfg_t               cfg
);

    csm_pkg::cfg_t                 cfg_reg;
    logic                          wr_en;
    logic [csm_pkg::REGIDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[csm_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imm_brake_dist <= csm_pkg::IMM_BRAKE_DIST_RST;
            cfg_reg.brake_dist     <= csm_pkg::BRAKE_DIST_RST;
            cfg_reg.brake_ttc      <= csm_pkg::BRAKE_TTC_RST;
            cfg_reg.warn_ttc       <= csm_pkg::WARN_TTC_RST;
            cfg_reg.warn_exit_ttc  <= csm_pkg::WARN_EXIT_TTC_RST;
            cfg_reg.confirm_frames <= csm_pkg::CONFIRM_FRAMES_RST;
            cfg_reg.resume_dist    <= csm_pkg::RESUME_DIST_RST;
            cfg_reg.stop_speed     <= csm_pkg::STOP_SPEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                csm_pkg::REG_IMM_BRAKE_DIST: cfg_reg.imm_brake_dist <= pwdata[15:0];
                csm_pkg::REG_BRAKE_DIST:     cfg_reg.brake_dist     <= pwdata[15:0];
                csm_pkg::REG_BRAKE_TTC:      cfg_reg.brake_ttc      <= pwdata[15:0];
                csm_pkg::REG_WARN_TTC:       cfg_reg.warn_ttc       <= pwdata[15:0];
                csm_pkg::REG_WARN_EXIT_TTC:  cfg_reg.warn_exit_ttc  <= pwdata[15:0];
                csm_pkg::REG_CONFIRM_FRAMES: cfg_reg.confirm_frames <= pwdata[7:0];
                csm_pkg::REG_RESUME_DIST:    cfg_reg.resume_dist    <= pwdata[15:0];
                csm_pkg::REG_STOP_SPEED:     cfg_reg.stop_speed     <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            csm_pkg::REG_IMM_BRAKE_DIST: prdata = {16'd0, cfg_reg.imm_brake_dist};
            csm_pkg::REG_BRAKE_DIST:     prdata = {16'd0, cfg_reg.brake_dist};
            csm_pkg::REG_BRAKE_TTC:      prdata = {16'd0, cfg_reg.brake_ttc};
            csm_pkg::REG_WARN_TTC:       prdata = {16'd0, cfg_reg.warn_ttc};
            csm_pkg::REG_WARN_EXIT_TTC:  prdata = {16'd0, cfg_reg.warn_exit_ttc};
            csm_pkg::REG_CONFIRM_FRAMES: prdata = {24'd0, cfg_reg.confirm_frames};
            csm_pkg::REG_RESUME_DIST:    prdata = {16'd0, cfg_reg.resume_dist};
            csm_pkg::REG_STOP_SPEED:     prdata = {18'd0, cfg_reg.stop_speed};
            default:                     prdata = '0;
        endcase
    end

endmodule

### rtl/csm_core.sv
// ----------------------------------------------------------------------------
// csm_core
// mode state machine with trigger counter, brake hold and fault recovery
// timers; state advances once per stepped item
// ----------------------------------------------------------------------------
module csm_core #(
    parameter int unsigned HOLD_TIME_MS     = csm_pkg::HOLD_TIME_MS_DEF,
    parameter int unsigned RECOVERY_TIME_MS = csm_pkg::RECOVERY_TIME_MS_DEF,
    parameter int unsigned FOLLOW_ENTER_Q8  = csm_pkg::FOLLOW_ENTER_Q8_DEF,
    parameter int unsigned FOLLOW_EXIT_Q8   = csm_pkg::FOLLOW_EXIT_Q8_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  csm_pkg::item_t item,
    input  csm_pkg::cfg_t  cfg,
    output csm_pkg::res_t  result
);

    localparam int PROD_W = csm_pkg::DIST_W + csm_pkg::Q8_W;

    csm_pkg::mode_t               mode_reg, mode_next;
    logic [csm_pkg::FRAME_W-1:0]  trig_reg, trig_next;
    logic                         hold_reg, hold_next;
    logic [csm_pkg::TIMER_W-1:0]  hold_tmr_reg, hold_tmr_next;
    logic [csm_pkg::TIMER_W-1:0]  rec_tmr_reg, rec_tmr_next;

    logic                         fault_entry;
    logic                         recovered;
    csm_pkg::mode_t               cur;
    logic [csm_pkg::TIMER_W-1:0]  rec_base;
    logic [csm_pkg::TIMER_W:0]    rec_sum;
    logic [csm_pkg::TIMER_W-1:0]  rec_sat;
    logic [csm_pkg::TIMER_W-1:0]  tick_ext;
    logic [csm_pkg::TIMER_W-1:0]  hold_dec;

    logic [PROD_W-1:0]            scaled;
    logic [PROD_W-1:0]            enter_lim;
    logic [PROD_W-1:0]            exit_lim;
    logic [csm_pkg::FRAME_W-1:0]  op_trig_in;
    logic [csm_pkg::FRAME_W-1:0]  trig_inc;
    csm_pkg::mode_t               op_mode;
    logic [csm_pkg::FRAME_W-1:0]  op_trig;

    // shared operating-mode pick
    assign scaled    = {2'd0, item.target_distance, 8'd0};
    assign enter_lim = item.desired_gap * csm_pkg::Q8_W'(FOLLOW_ENTER_Q8);
    assign exit_lim  = item.desired_gap * csm_pkg::Q8_W'(FOLLOW_EXIT_Q8);
    assign op_trig_in = (cur == csm_pkg::MODE_FAULT || hold_reg) ? '0 : trig_reg;
    assign trig_inc  = (op_trig_in == '1) ? op_trig_in : op_trig_in + 8'd1;

    always_comb
    begin
        op_trig = '0;
        op_mode = csm_pkg::MODE_CRUISE;
        priority if (item.target_stale)
        begin
            op_mode = cur;
        end
        else if (!item.target_valid)
        begin
            op_mode = csm_pkg::MODE_CRUISE;
        end
        else if (item.target_distance < cfg.imm_brake_dist)
        begin
            op_trig = cfg.confirm_frames;
            op_mode = csm_pkg::MODE_BRAKE;
        end
        else if (item.time_to_collision < cfg.brake_ttc ||
                 item.target_distance < cfg.brake_dist)
        begin
            op_trig = trig_inc;
            op_mode = (trig_inc >= cfg.confirm_frames) ? csm_pkg::MODE_BRAKE
                                                       : csm_pkg::MODE_WARN;
        end
        else if (item.time_to_collision < cfg.warn_ttc)
        begin
            op_mode = csm_pkg::MODE_WARN;
        end
        else if (cur == csm_pkg::MODE_WARN && item.time_to_collision < cfg.warn_exit_ttc)
        begin
            op_mode = csm_pkg::MODE_WARN;
        end
        else if (scaled <= enter_lim)
        begin
            op_mode = csm_pkg::MODE_FOLLOW;
        end
        else if (cur == csm_pkg::MODE_FOLLOW && scaled <= exit_lim)
        begin
            op_mode = csm_pkg::MODE_FOLLOW;
        end
        else
        begin
            op_mode = csm_pkg::MODE_CRUISE;
        end
    end

    // timers
    assign fault_entry = !item.sensors_healthy && (mode_reg != csm_pkg::MODE_FAULT);
    assign cur         = fault_entry ? csm_pkg::MODE_FAULT : mode_reg;
    assign rec_base    = fault_entry ? '0 : rec_tmr_reg;
    assign tick_ext    = {6'd0, item.tick_ms};
    assign rec_sum     = {1'b0, rec_base} + {1'b0, tick_ext};
    assign rec_sat     = rec_sum[csm_pkg::TIMER_W] ? '1 : rec_sum[csm_pkg::TIMER_W-1:0];
    assign hold_dec    = (hold_tmr_reg > tick_ext) ? hold_tmr_reg - tick_ext : '0;
    assign recovered   = (cur == csm_pkg::MODE_FAULT) && item.sensors_healthy &&
                         (rec_sat >= csm_pkg::TIMER_W'(RECOVERY_TIME_MS));

    // next state
    always_comb
    begin
        mode_next     = cur;
        trig_next     = trig_reg;
        hold_next     = hold_reg;
        hold_tmr_next = hold_tmr_reg;
        rec_tmr_next  = rec_tmr_reg;
        priority if (cur == csm_pkg::MODE_FAULT)
        begin
            hold_next = 1'b0;
            trig_next = '0;
            mode_next = csm_pkg::MODE_FAULT;
            if (!item.sensors_healthy)
            begin
                rec_tmr_next = '0;
            end
            else if (recovered)
            begin
                rec_tmr_next = '0;
                mode_next    = op_mode;
                trig_next    = op_trig;
            end
            else
            begin
                rec_tmr_next = rec_sat;
            end
        end
        else if (hold_reg)
        begin
            trig_next     = '0;
            hold_tmr_next = hold_dec;
            if (hold_dec == '0 &&
                (!item.target_valid || item.target_distance > cfg.resume_dist))
            begin
                hold_next = 1'b0;
                mode_next = op_mode;
                trig_next = op_trig;
            end
            else
            begin
                mode_next = csm_pkg::MODE_BRAKE;
            end
        end
        else if (cur == csm_pkg::MODE_BRAKE)
        begin
            if (item.ego_speed < cfg.stop_speed)
            begin
                trig_next     = '0;
                hold_next     = 1'b1;
                hold_tmr_next = csm_pkg::TIMER_W'(HOLD_TIME_MS);
            end
            mode_next = csm_pkg::MODE_BRAKE;
        end
        else
        begin
            mode_next = op_mode;
            trig_next = op_trig;
        end
    end

    // outputs
    always_comb
    begin
        result.mode = mode_next;
        result.hold = hold_next;
        priority if (fault_entry)
            result.evt = csm_pkg::EVT_FAULT_ENTERED;
        else if (recovered)
            result.evt = csm_pkg::EVT_RECOVERED;
        else
            result.evt = csm_pkg::EVT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= csm_pkg::MODE_CRUISE;
            trig_reg     <= '0;
            hold_reg     <= 1'b0;
            hold_tmr_reg <= '0;
            rec_tmr_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            trig_reg     <= trig_next;
            hold_reg     <= hold_next;
            hold_tmr_reg <= hold_tmr_next;
            rec_tmr_reg  <= rec_tmr_next;
        end
    end

endmodule

### rtl/collision_safety_mode_fsm.sv
// ----------------------------------------------------------------------------
// collision_safety_mode_fsm
// per-tick choice of cruise, follow, warn, emergency brake or fault mode
// path: input transfer into the input register, then the mode decision
//   into the result register; a receiver stall holds the item between them
// throughput: one item per cycle while out_stall is low
// reset: mode cruise, counters, timers and hold cleared, thresholds at
//   their defaults; no result pending
// ----------------------------------------------------------------------------
module collision_safety_mode_fsm #(
    parameter int unsigned HOLD_TIME_MS     = csm_pkg::HOLD_TIME_MS_DEF,
    parameter int unsigned RECOVERY_TIME_MS = csm_pkg::RECOVERY_TIME_MS_DEF,
    parameter int unsigned FOLLOW_ENTER_Q8  = csm_pkg::FOLLOW_ENTER_Q8_DEF,
    parameter int unsigned FOLLOW_EXIT_Q8   = csm_pkg::FOLLOW_EXIT_Q8_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csm_pkg::ADDR_W-1:0]   paddr,
    input  logic [csm_pkg::DATA_W-1:0]   pwdata,
    output logic [csm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         sensors_healthy,
    input  logic                         target_valid,
    input  logic                         target_stale,
    input  logic [csm_pkg::DIST_W-1:0]   target_distance,
    input  logic [csm_pkg::DIST_W-1:0]   desired_gap,
    input  logic [csm_pkg::TTC_W-1:0]    time_to_collision,
    input  logic [csm_pkg::SPEED_W-1:0]  ego_speed,
    input  logic [csm_pkg::TICK_W-1:0]   tick_ms,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   safety_mode,
    output logic [1:0]                   mode_event,
    output logic                         hold_active
);

    csm_pkg::cfg_t   cfg;
    csm_pkg::item_t  item_reg;
    csm_pkg::res_t   res_reg;
    csm_pkg::res_t   core_res;
    logic            in_vld_reg, in_vld_next;
    logic            out_vld_reg, out_vld_next;
    logic            load_in;
    logic            advance;

    csm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csm_core #(
        .HOLD_TIME_MS     (HOLD_TIME_MS),
        .RECOVERY_TIME_MS (RECOVERY_TIME_MS),
        .FOLLOW_ENTER_Q8  (FOLLOW_ENTER_Q8),
        .FOLLOW_EXIT_Q8   (FOLLOW_EXIT_Q8)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (load_in)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            item_reg.sensors_healthy   <= sensors_healthy;
            item_reg.target_valid      <= target_valid;
            item_reg.target_stale      <= target_stale;
            item_reg.target_distance   <= target_distance;
            item_reg.desired_gap       <= desired_gap;
            item_reg.time_to_collision <= time_to_collision;
            item_reg.ego_speed         <= ego_speed;
            item_reg.tick_ms           <= tick_ms;
        end
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign safety_mode = res_reg.mode;
    assign mode_event  = res_reg.evt;
    assign hold_active = res_reg.hold;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the collision safety mode selector against its own copy of the mode
// rules. A short table of ticks covers the extremes, every mode and event,
// hold release and fault recovery, and stale targets. Random traffic follows,
// shaped into threat, following, clearing and sensor dropout stretches under
// several threshold settings. Sender gaps and receiver stalls are random.
// Every result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import csm_pkg::*;

    typedef enum int {
        TH_NOISE,
        TH_THREAT,
        TH_FOLLOW,
        TH_CLEAR,
        TH_DROPOUT
    } theme_t;

    typedef enum int {
        CFG_RANDOM,
        CFG_ZERO_CONFIRM,
        CFG_DEFAULT,
        CFG_ALL_ZERO,
        CFG_ALL_MAX,
        CFG_SINGLE_FRAME
    } cfg_kind_t;

    typedef struct {
        item_t it;
        bit    typed;
        res_t  want;
    } row_t;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 85;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;

    localparam cfg_t CFG_RESET = '{IMM_BRAKE_DIST_RST, BRAKE_DIST_RST, BRAKE_TTC_RST,
                                   WARN_TTC_RST, WARN_EXIT_TTC_RST, CONFIRM_FRAMES_RST,
                                   RESUME_DIST_RST, STOP_SPEED_RST};
    localparam res_t UNTYPED   = '{MODE_CRUISE, EVT_NONE, 1'b0};

    // ok, valid, stale, distance, gap, ttc, speed, tick
    row_t dir_rows [25] = '{
        '{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, '{MODE_CRUISE, EVT_NONE, 1'b0}},
        '{'{1, 1, 0, 65535, 0, 65535, 10000, 1000}, 1, '{MODE_CRUISE, EVT_NONE, 1'b0}},
        '{'{1, 1, 0, 2000, 65535, 65535, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 1200, 750, 65535, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 2900, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 3200, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 4000, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 1400, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 1400, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 1400, 1000, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 5000, 0, 1400, 10, 100}, 0, UNTYPED},
        '{'{1, 1, 0, 100, 0, 0, 0, 1000}, 0, UNTYPED},
        '{'{1, 1, 0, 100, 0, 0, 0, 1000}, 0, UNTYPED},
        '{'{1, 1, 1, 1000, 0, 65535, 0, 0}, 0, UNTYPED},
        '{'{1, 1, 0, 1000, 0, 65535, 5, 0}, 0, UNTYPED},
        '{'{1, 0, 0, 0, 0, 65535, 0, 1023}, 0, UNTYPED},
        '{'{1, 0, 0, 0, 0, 65535, 0, 1023}, 0, UNTYPED},
        '{'{1, 1, 0, 0, 0, 65535, 16383, 0}, 0, UNTYPED},
        '{'{0, 1, 0, 0, 0, 65535, 16383, 1000}, 1, '{MODE_FAULT, EVT_FAULT_ENTERED, 1'b0}},
        '{'{1, 1, 1, 5000, 0, 65535, 0, 1000}, 0, UNTYPED},
        '{'{1, 0, 0, 0, 0, 65535, 0, 999}, 0, UNTYPED},
        '{'{1, 0, 0, 0, 0, 65535, 0, 1}, 0, UNTYPED},
        '{'{0, 0, 0, 0, 0, 0, 0, 1023}, 1, '{MODE_FAULT, EVT_FAULT_ENTERED, 1'b0}},
        '{'{0, 0, 0, 0, 0, 0, 0, 1023}, 1, '{MODE_FAULT, EVT_NONE, 1'b0}},
        '{'{1, 0, 0, 0, 0, 0, 0, 0}, 0, UNTYPED}
    };

    cfg_kind_t schedule [PHASES] = '{CFG_RANDOM, CFG_ZERO_CONFIRM, CFG_DEFAULT, CFG_ALL_ZERO,
                                     CFG_RANDOM, CFG_ALL_MAX, CFG_SINGLE_FRAME, CFG_RANDOM,
                                     CFG_ZERO_CONFIRM, CFG_DEFAULT};

    logic                 clk               = 1'b0;
    logic                 rst_n             = 1'b0;
    logic                 psel              = 1'b0;
    logic                 penable           = 1'b0;
    logic                 pwrite            = 1'b0;
    logic [ADDR_W-1:0]    paddr             = '0;
    logic [DATA_W-1:0]    pwdata            = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid          = 1'b0;
    logic                 in_stall;
    logic                 sensors_healthy   = 1'b0;
    logic                 target_valid      = 1'b0;
    logic                 target_stale      = 1'b0;
    logic [DIST_W-1:0]    target_distance   = '0;
    logic [DIST_W-1:0]    desired_gap       = '0;
    logic [TTC_W-1:0]     time_to_collision = '0;
    logic [SPEED_W-1:0]   ego_speed         = '0;
    logic [TICK_W-1:0]    tick_ms           = '0;
    logic                 out_valid;
    logic                 out_stall         = 1'b0;
    logic [2:0]           safety_mode;
    logic [1:0]           mode_event;
    logic                 hold_active;

    // predictor state
    cfg_t                 cfg;
    mode_t                cur_mode;
    logic [FRAME_W-1:0]   trig_cnt;
    logic                 hold_flag;
    logic [TIMER_W-1:0]   hold_tmr;
    logic [TIMER_W-1:0]   recov_tmr;

    res_t                 results_due [$];
    res_t                 due_head;
    int                   fail_count      = 0;
    int                   ticks_sent      = 0;
    int                   results_checked = 0;
    int                   settings_run    = 1;
    int                   mode_hits [5]   = '{0, 0, 0, 0, 0};
    int                   burst_left      = 4;
    int                   stall_run       = 0;
    int                   quiet_cycles    = 0;
    bit                   calm            = 1'b0;

    collision_safety_mode_fsm dut (.*);

    always #2 clk = ~clk;

    function automatic logic [15:0] near(input int unsigned base);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, 8)) - 4;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    function automatic mode_t pick_mode(input mode_t cur, input item_t it);
        int unsigned scaled;
        int unsigned enter_lim;
        int unsigned exit_lim;
        scaled    = 32'(it.target_distance) << 8;
        enter_lim = 32'(it.desired_gap) * FOLLOW_ENTER_Q8_DEF;
        exit_lim  = 32'(it.desired_gap) * FOLLOW_EXIT_Q8_DEF;
        if (it.target_stale)
        begin
            trig_cnt = '0;
            return cur;
        end
        if (!it.target_valid)
        begin
            trig_cnt = '0;
            return MODE_CRUISE;
        end
        if (it.target_distance < cfg.imm_brake_dist)
        begin
            trig_cnt = cfg.confirm_frames;
            return MODE_BRAKE;
        end
        if (it.time_to_collision < cfg.brake_ttc || it.target_distance < cfg.brake_dist)
        begin
            if (trig_cnt != 8'hFF)
            begin
                trig_cnt = trig_cnt + 1'b1;
            end
            return (trig_cnt >= cfg.confirm_frames) ? MODE_BRAKE : MODE_WARN;
        end
        trig_cnt = '0;
        if (it.time_to_collision < cfg.warn_ttc)
        begin
            return MODE_WARN;
        end
        if (cur == MODE_WARN && it.time_to_collision < cfg.warn_exit_ttc)
        begin
            return MODE_WARN;
        end
        if (scaled <= enter_lim)
        begin
            return MODE_FOLLOW;
        end
        if (cur == MODE_FOLLOW && scaled <= exit_lim)
        begin
            return MODE_FOLLOW;
        end
        return MODE_CRUISE;
    endfunction

    function automatic res_t next_mode_result(input item_t it);
        event_t      evt;
        mode_t       cur;
        mode_t       nxt;
        logic [16:0] sum;
        res_t        r;
        evt = EVT_NONE;
        if (!it.sensors_healthy && cur_mode != MODE_FAULT)
        begin
            cur_mode  = MODE_FAULT;
            recov_tmr = '0;
            evt       = EVT_FAULT_ENTERED;
        end
        cur = cur_mode;
        if (cur == MODE_FAULT)
        begin
            hold_flag = 1'b0;
            trig_cnt  = '0;
            nxt       = MODE_FAULT;
            if (it.sensors_healthy)
            begin
                sum       = {1'b0, recov_tmr} + it.tick_ms;
                recov_tmr = sum[16] ? 16'hFFFF : sum[15:0];
                if (recov_tmr >= RECOVERY_TIME_MS_DEF)
                begin
                    recov_tmr = '0;
                    if (evt == EVT_NONE)
                    begin
                        evt = EVT_RECOVERED;
                    end
                    nxt = pick_mode(cur, it);
                end
            end
            else
            begin
                recov_tmr = '0;
            end
        end
        else if (hold_flag)
        begin
            trig_cnt = '0;
            hold_tmr = (hold_tmr > it.tick_ms) ? hold_tmr - it.tick_ms : '0;
            if (hold_tmr == '0 && (!it.target_valid || it.target_distance > cfg.resume_dist))
            begin
                hold_flag = 1'b0;
                nxt       = pick_mode(cur, it);
            end
            else
            begin
                nxt = MODE_BRAKE;
            end
        end
        else if (cur == MODE_BRAKE)
        begin
            if (it.ego_speed < cfg.stop_speed)
            begin
                trig_cnt  = '0;
                hold_flag = 1'b1;
                hold_tmr  = 16'(HOLD_TIME_MS_DEF);
            end
            nxt = MODE_BRAKE;
        end
        else
        begin
            nxt = pick_mode(cur, it);
        end
        cur_mode = nxt;
        r.mode   = cur_mode;
        r.evt    = evt;
        r.hold   = hold_flag;
        return r;
    endfunction

    task automatic reg_write(input logic [REGIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMM_BRAKE_DIST: cfg.imm_brake_dist = val[DIST_W-1:0];
            REG_BRAKE_DIST:     cfg.brake_dist     = val[DIST_W-1:0];
            REG_BRAKE_TTC:      cfg.brake_ttc      = val[TTC_W-1:0];
            REG_WARN_TTC:       cfg.warn_ttc       = val[TTC_W-1:0];
            REG_WARN_EXIT_TTC:  cfg.warn_exit_ttc  = val[TTC_W-1:0];
            REG_CONFIRM_FRAMES: cfg.confirm_frames = val[FRAME_W-1:0];
            REG_RESUME_DIST:    cfg.resume_dist    = val[DIST_W-1:0];
            default:            cfg.stop_speed     = val[SPEED_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one tick transfer, then the sender's burst and gap pattern
    task automatic feed(input item_t it, input bit typed, input res_t want);
        res_t predicted;
        in_valid          <= 1'b1;
        sensors_healthy   <= it.sensors_healthy;
        target_valid      <= it.target_valid;
        target_stale      <= it.target_stale;
        target_distance   <= it.target_distance;
        desired_gap       <= it.desired_gap;
        time_to_collision <= it.time_to_collision;
        ego_speed         <= it.ego_speed;
        tick_ms           <= it.tick_ms;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = next_mode_result(it);
        results_due.push_back(typed ? want : predicted);
        ticks_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!calm)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                if ($urandom_range(0, 24) == 0)
                begin
                    drain();
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
        end
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with nothing expected: safety_mode %0d mode_event %0d",
                       safety_mode, mode_event);
                fail_count++;
            end
            else
            begin
                due_head = results_due.pop_front();
                if (safety_mode !== due_head.mode)
                begin
                    $error("safety_mode expected %0d actual %0d", due_head.mode, safety_mode);
                    fail_count++;
                end
                if (mode_event !== due_head.evt)
                begin
                    $error("mode_event expected %0d actual %0d", due_head.evt, mode_event);
                    fail_count++;
                end
                if (hold_active !== due_head.hold)
                begin
                    $error("hold_active expected %0d actual %0d", due_head.hold, hold_active);
                    fail_count++;
                end
                mode_hits[int'(due_head.mode)]++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        item_t       it;
        cfg_t        c;
        logic [95:0] raw;
        int unsigned gap;
        int unsigned pick;
        theme_t      theme;

        theme     = TH_NOISE;
        cfg       = CFG_RESET;
        cur_mode  = MODE_CRUISE;
        trig_cnt  = '0;
        hold_flag = 1'b0;
        hold_tmr  = '0;
        recov_tmr = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            feed(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        end
        in_valid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            c.imm_brake_dist = 16'($urandom_range(0, 1500));
            c.brake_dist     = c.imm_brake_dist + 16'($urandom_range(0, 1500));
            c.brake_ttc      = 16'($urandom_range(0, 3000));
            c.warn_ttc       = c.brake_ttc + 16'($urandom_range(0, 2000));
            c.warn_exit_ttc  = c.warn_ttc + 16'($urandom_range(0, 1000));
            c.confirm_frames = 8'($urandom_range(1, 6));
            c.resume_dist    = 16'($urandom_range(0, 2000));
            c.stop_speed     = 14'($urandom_range(0, 300));
            case (schedule[ph])
                CFG_ZERO_CONFIRM: c.confirm_frames = '0;
                CFG_DEFAULT:      c = CFG_RESET;
                CFG_ALL_ZERO:     c = '0;
                CFG_ALL_MAX:      c = '1;
                CFG_SINGLE_FRAME: c.confirm_frames = 8'd1;
                default:          ;
            endcase
            reg_write(REG_IMM_BRAKE_DIST, 32'(c.imm_brake_dist));
            reg_write(REG_BRAKE_DIST, 32'(c.brake_dist));
            reg_write(REG_BRAKE_TTC, 32'(c.brake_ttc));
            reg_write(REG_WARN_TTC, 32'(c.warn_ttc));
            reg_write(REG_WARN_EXIT_TTC, 32'(c.warn_exit_ttc));
            reg_write(REG_CONFIRM_FRAMES, 32'(c.confirm_frames));
            reg_write(REG_RESUME_DIST, 32'(c.resume_dist));
            reg_write(REG_STOP_SPEED, 32'(c.stop_speed));
            settings_run++;
            calm = (ph == 2 || ph == 6);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 0 || $urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       theme = TH_NOISE;
                        1, 2, 3: theme = TH_THREAT;
                        4, 5:    theme = TH_FOLLOW;
                        6, 7:    theme = TH_CLEAR;
                        default: theme = TH_DROPOUT;
                    endcase
                end
                raw = {$urandom, $urandom, $urandom};
                it  = item_t'(raw[$bits(item_t)-1:0]);
                if (theme != TH_NOISE)
                begin
                    it.sensors_healthy = ($urandom_range(0, 39) != 0);
                    it.target_valid    = ($urandom_range(0, 9) != 0);
                    it.target_stale    = ($urandom_range(0, 14) == 0);
                    it.tick_ms         = ($urandom_range(0, 3) == 0) ?
                                         10'($urandom_range(0, 1023)) :
                                         10'($urandom_range(100, 1000));
                    it.ego_speed       = ($urandom_range(0, 1) == 0) ?
                                         14'($urandom_range(0, cfg.stop_speed + 4)) :
                                         14'($urandom_range(0, 10000));
                end
                case (theme)
                    TH_THREAT:
                    begin
                        pick = $urandom_range(0, 2);
                        it.target_distance = (pick == 0) ? near(cfg.imm_brake_dist) :
                                             (pick == 1) ? near(cfg.brake_dist) :
                                             16'($urandom_range(0, 3000));
                        pick = $urandom_range(0, 2);
                        it.time_to_collision = (pick == 0) ? near(cfg.brake_ttc) :
                                               (pick == 1) ? 16'($urandom_range(0, 4000)) :
                                               16'hFFFF;
                    end
                    TH_FOLLOW:
                    begin
                        gap            = $urandom_range(0, 8000);
                        it.desired_gap = 16'(gap);
                        it.target_distance = ($urandom_range(0, 1) == 0) ?
                                             near((gap * FOLLOW_ENTER_Q8_DEF) >> 8) :
                                             near((gap * FOLLOW_EXIT_Q8_DEF) >> 8);
                        pick = $urandom_range(0, 3);
                        it.time_to_collision = (pick == 0) ? near(cfg.warn_ttc) :
                                               (pick == 1) ? near(cfg.warn_exit_ttc) :
                                               (pick == 2) ? 16'($urandom_range(0, 6000)) :
                                               16'hFFFF;
                    end
                    TH_CLEAR:
                    begin
                        it.target_valid      = 1'($urandom_range(0, 1));
                        it.target_distance   = ($urandom_range(0, 1) == 0) ?
                                               near(cfg.resume_dist) :
                                               16'($urandom_range(0, 65535));
                        it.time_to_collision = 16'hFFFF;
                        it.ego_speed         = 14'($urandom_range(0, 40));
                    end
                    TH_DROPOUT:
                    begin
                        it.sensors_healthy = ($urandom_range(0, 2) != 0);
                        it.tick_ms         = 10'($urandom_range(200, 1023));
                    end
                    default: ;
                endcase
                feed(it, 1'b0, UNTYPED);
            end
            in_valid <= 1'b0;
            drain();
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        calm = 1'b0;
        drain();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d control ticks under %0d threshold settings, %0d results compared",
                 ticks_sent, settings_run, results_checked);
        $display("summary: cruise %0d, follow %0d, warn %0d, brake %0d, fault %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
        if (fail_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
